>>> rtl/core/gmca_pkg.sv
// ----------------------------------------------------------------------------
// gmca_pkg: shared types and constants of the gain/mix/clip audio block
// Sample and result structs, volume limits and internal word widths.
// ----------------------------------------------------------------------------
package gmca_pkg;

  localparam int unsigned HwChannels         = 4;
  localparam int unsigned NumChannelsDefault = 4;

  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 10;
  localparam int unsigned MaskW   = HwChannels;

  // signed sample times unsigned volume (one guard bit for the sign)
  localparam int unsigned ProdW = SampleW + VolW + 1;
  localparam int unsigned FracW = 8;
  localparam int unsigned TermW = ProdW - FracW;
  // four terms of at most +/-2^16 each
  localparam int unsigned SumW  = 20;

  localparam int unsigned RegIdxW  = 2;
  localparam int unsigned RegAddrW = RegIdxW + 2;
  localparam int unsigned DataW    = 32;

  localparam logic [VolW-1:0] VolUnity = 10'h100;
  localparam logic [VolW-1:0] VolMax   = 10'h200;

  localparam logic signed [SumW-1:0] ClipPos = 20'sh07fff;
  localparam logic signed [SumW-1:0] ClipNeg = -20'sh07fff;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_0;
    logic signed [SampleW-1:0] sample_1;
    logic signed [SampleW-1:0] sample_2;
    logic signed [SampleW-1:0] sample_3;
    logic        [MaskW-1:0]   present_mask;
  } gmca_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mixed_sample;
    logic                      idle;
  } gmca_result_t;

endpackage

>>> rtl/core/gain_mix_clip_audio.sv
// ----------------------------------------------------------------------------
// gain_mix_clip_audio: per-channel gain, mix and symmetric clip
// Takes one transaction per clock when start_i is high; busy_o never rises.
// Every transaction yields exactly one result. A transaction accepted at a
// clock edge lands in the input register; gain, sum and clip are settled by
// the next edge, which loads the result register, so result_valid_o strobes
// in the cycle after that. Nothing stalls: the receiver cannot hold results
// off, so results come out at the input rate, one per clock. Each present
// channel is scaled by its Q2.8 volume (floor shift by 8), the terms are
// summed and clipped to +/-32767; no channel present gives 0 with idle set.
// Volumes sit on an APB port at byte address 4*channel and reset to unity
// (256); writes whose low 10 bits exceed 512 are dropped.
// ----------------------------------------------------------------------------
module gain_mix_clip_audio #(
  parameter int unsigned CHAN_COUNT = gmca_pkg::NumChannelsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  gmca_pkg::gmca_item_t            item_i,
  output logic                            result_valid_o,
  output gmca_pkg::gmca_result_t          result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gmca_pkg::RegAddrW-1:0]   paddr,
  input  logic [gmca_pkg::DataW-1:0]      pwdata,
  output logic [gmca_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned ActiveCh =
      (CHAN_COUNT < gmca_pkg::HwChannels) ? CHAN_COUNT : gmca_pkg::HwChannels;

  // --------------------------------------------------------------------------
  // Volume registers
  // --------------------------------------------------------------------------
  logic [gmca_pkg::VolW-1:0]    vol_q [ActiveCh];
  logic [gmca_pkg::RegIdxW-1:0] reg_idx;
  logic [gmca_pkg::VolW-1:0]    wr_vol;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gmca_pkg::RegAddrW-1:2];
  assign wr_vol  = pwdata[gmca_pkg::VolW-1:0];
  assign wr_en   = psel && penable && pwrite && pready && (wr_vol <= gmca_pkg::VolMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ActiveCh; i++) begin
        vol_q[i] <= gmca_pkg::VolUnity;
      end
    end else if (wr_en) begin
      for (int i = 0; i < ActiveCh; i++) begin
        if (reg_idx == gmca_pkg::RegIdxW'(i)) begin
          vol_q[i] <= wr_vol;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < ActiveCh; i++) begin
      if (reg_idx == gmca_pkg::RegIdxW'(i)) begin
        prdata = gmca_pkg::DataW'(vol_q[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                 s0_valid_q;
  gmca_pkg::gmca_item_t s0_item_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s0_item_q <= item_i;
    end
  end

  // --------------------------------------------------------------------------
  // Per-channel gain, sum, clip, result register
  // --------------------------------------------------------------------------
  logic signed [gmca_pkg::SampleW-1:0] smp      [gmca_pkg::HwChannels];
  logic signed [gmca_pkg::TermW-1:0]   term_d   [ActiveCh];
  logic                                any_present;
  logic signed [gmca_pkg::SumW-1:0]    sum;
  logic signed [gmca_pkg::SumW-1:0]    clipped;
  logic                                out_valid_q;
  gmca_pkg::gmca_result_t              out_q;

  assign smp[0] = s0_item_q.sample_0;
  assign smp[1] = s0_item_q.sample_1;
  assign smp[2] = s0_item_q.sample_2;
  assign smp[3] = s0_item_q.sample_3;

  always_comb begin
    logic signed [gmca_pkg::ProdW-1:0] prod;
    any_present = 1'b0;
    for (int n = 0; n < ActiveCh; n++) begin
      prod = smp[n] * $signed({1'b0, vol_q[n]});
      // dropping the low bits of a two's-complement product is a floor shift
      term_d[n] = s0_item_q.present_mask[n] ?
                  prod[gmca_pkg::ProdW-1:gmca_pkg::FracW] : '0;
      any_present = any_present | s0_item_q.present_mask[n];
    end
  end

  always_comb begin
    sum = '0;
    for (int n = 0; n < ActiveCh; n++) begin
      sum = sum + gmca_pkg::SumW'(term_d[n]);
    end
    priority if (sum > gmca_pkg::ClipPos) begin
      clipped = gmca_pkg::ClipPos;
    end else if (sum < gmca_pkg::ClipNeg) begin
      clipped = gmca_pkg::ClipNeg;
    end else begin
      clipped = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid_q) begin
      out_q.mixed_sample <= !any_present ? '0 : clipped[gmca_pkg::SampleW-1:0];
      out_q.idle         <= !any_present;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 result_valid_o)
    else $error("accepted transaction produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without matching transaction");

  a_idle_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.idle |-> result_o.mixed_sample == '0)
    else $error("idle result carries nonzero sample");

  a_clip_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.mixed_sample != 16'sh8000)
    else $error("mixed sample outside symmetric clip range");

  a_vol0_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vol_q[0] <= gmca_pkg::VolMax)
    else $error("channel 0 volume above limit");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gain_mix_clip_audio
// Drives sample transactions on the start/busy port and volumes over APB. A
// local gain/mix/clip predictor queues one expected result per accepted
// transaction, and a monitor compares every strobed result with it. The run
// covers directed extremes, volume limits and random traffic with idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import gmca_pkg::*;

  localparam int unsigned NumCh        = NumChannelsDefault;
  localparam int          HalfPeriod   = 6;
  localparam int          SettleCycles = 4;
  localparam int          CycleLimit   = 200000;
  localparam int          MixPhases    = 8;
  localparam int          PhaseItems   = 245;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  gmca_item_t          item_i;
  logic                result_valid_o;
  gmca_result_t        result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  logic [VolW-1:0] vol_q [HwChannels];
  gmca_result_t    mix_exp_q [$];
  int              err_cnt;
  int              cycle_cnt;

  gain_mix_clip_audio #(
    .CHAN_COUNT(NumCh)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Floor-shifted Q2.8 gain per present channel, summed, clipped to +/-32767.
  function automatic gmca_result_t mix_predict(input gmca_item_t it);
    logic signed [SampleW-1:0] smp [HwChannels];
    int           acc;
    int           prod;
    bit           any;
    gmca_result_t r;
    smp[0] = it.sample_0;
    smp[1] = it.sample_1;
    smp[2] = it.sample_2;
    smp[3] = it.sample_3;
    acc = 0;
    any = 1'b0;
    for (int n = 0; n < HwChannels; n++) begin
      if (n < NumCh && it.present_mask[n]) begin
        any  = 1'b1;
        prod = int'(smp[n]) * int'({22'b0, vol_q[n]});
        acc  += prod >>> FracW;
      end
    end
    if (!any) begin
      r.mixed_sample = '0;
      r.idle         = 1'b1;
    end else begin
      if (acc > 32767) acc = 32767;
      if (acc < -32767) acc = -32767;
      r.mixed_sample = acc[SampleW-1:0];
      r.idle         = 1'b0;
    end
    return r;
  endfunction

  function automatic gmca_item_t mk_item(input int s0, input int s1, input int s2,
                                         input int s3, input int mask);
    gmca_item_t it;
    it.sample_0     = s0[SampleW-1:0];
    it.sample_1     = s1[SampleW-1:0];
    it.sample_2     = s2[SampleW-1:0];
    it.sample_3     = s3[SampleW-1:0];
    it.present_mask = mask[MaskW-1:0];
    return it;
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    logic [SampleW-1:0] s;
    case ($urandom_range(15))
      0:       s = 16'h7fff;
      1:       s = 16'h8000;
      2:       s = 16'h0000;
      3:       s = 16'hffff;
      default: s = SampleW'($urandom());
    endcase
    return s;
  endfunction

  function automatic gmca_item_t rand_item();
    gmca_item_t it;
    it.sample_0     = rand_sample();
    it.sample_1     = rand_sample();
    it.sample_2     = rand_sample();
    it.sample_3     = rand_sample();
    it.present_mask = MaskW'($urandom_range(15));
    return it;
  endfunction

  // Sends one transaction after a random gap; start_i stays high across
  // back-to-back transactions.
  task automatic send_item(input gmca_item_t it, input int idle_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    item_i  = it;
    do @(posedge clk_i); while (busy_o);
    mix_exp_q.push_back(mix_predict(it));
  endtask

  // Stops traffic and waits until every result is back.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (mix_exp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input int idx, input logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = RegAddrW'(idx * 4);
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_volume(input int idx);
    logic [DataW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== {22'b0, vol_q[idx]})
      flag_error($sformatf("volume_%0d readback exp %0d got %0d", idx, vol_q[idx], rd));
  endtask

  // Only the low 10 bits count; values above the max leave the register as is.
  task automatic write_volume(input int idx, input logic [DataW-1:0] data);
    logic [DataW-1:0] rd;
    drain();
    apb_access(1'b1, idx, data, rd);
    if (data[VolW-1:0] <= VolMax) vol_q[idx] = data[VolW-1:0];
    check_volume(idx);
  endtask

  task automatic test_unity_mix();
    for (int c = 0; c < HwChannels; c++) check_volume(c);
    send_item(mk_item(32767, 32767, 32767, 32767, 15), 0);
    send_item(mk_item(-32768, -32768, -32768, -32768, 15), 0);
    send_item(mk_item(-32768, 0, 0, 0, 1), 0);
    send_item(mk_item(32767, 32767, 0, 0, 3), 0);
    send_item(mk_item(1234, -32768, 32767, -1, 0), 0);
    send_item(mk_item(0, 0, 0, 0, 0), 0);
    send_item(mk_item(-12345, 999, 999, 999, 1), 0);
    send_item(mk_item(999, 32767, 999, 999, 2), 0);
    send_item(mk_item(999, 999, -32768, 999, 4), 0);
    send_item(mk_item(999, 999, 999, 20000, 8), 0);
    send_item(mk_item(20000, -20000, 15000, -15000, 15), 0);
  endtask

  task automatic test_volume_limits();
    for (int c = 0; c < HwChannels; c++) write_volume(c, 32'd0);
    send_item(mk_item(32767, -32768, 32767, -32768, 15), 0);
    for (int c = 0; c < HwChannels; c++) write_volume(c, {22'b0, VolMax});
    send_item(mk_item(0, 0, 0, 32767, 8), 0);
    send_item(mk_item(0, 0, -32768, 0, 4), 0);
    send_item(mk_item(0, 100, 0, 0, 2), 0);
    // out-of-range writes must be dropped
    write_volume(0, 32'd513);
    write_volume(1, 32'd1023);
    write_volume(2, 32'hffff_fe01);
    // upper data bits are don't-care
    for (int c = 0; c < HwChannels; c++) write_volume(c, 32'hffff_fc01);
    // floor rounding of the shift on small magnitudes
    send_item(mk_item(-1, 0, 0, 0, 1), 0);
    send_item(mk_item(0, 255, 0, 0, 2), 0);
    send_item(mk_item(0, 0, -256, 0, 4), 0);
    send_item(mk_item(0, 0, 0, -257, 8), 0);
    send_item(mk_item(-1, 255, -256, -257, 15), 0);
  endtask

  function automatic logic [DataW-1:0] rand_volume_word();
    logic [DataW-1:0] w;
    w = '0;
    case ($urandom_range(7))
      0:       w[VolW-1:0] = '0;
      1:       w[VolW-1:0] = VolMax;
      2:       w[VolW-1:0] = VolUnity;
      3:       w[VolW-1:0] = 10'd1;
      default: w[VolW-1:0] = VolW'($urandom_range(512));
    endcase
    if ($urandom_range(3) == 0) w[DataW-1:VolW] = (DataW-VolW)'($urandom());
    return w;
  endfunction

  task automatic test_random_mix();
    int idle_pct [3];
    idle_pct = '{0, 83, 38};
    for (int ph = 0; ph < MixPhases; ph++) begin
      for (int c = 0; c < HwChannels; c++) begin
        if ($urandom_range(4) == 0) write_volume(c, $urandom_range(1023, 513));
        write_volume(c, rand_volume_word());
      end
      for (int i = 0; i < PhaseItems; i++) send_item(rand_item(), idle_pct[ph % 3]);
    end
  endtask

  // Result monitor: one expectation consumed per strobe.
  always @(posedge clk_i) begin
    gmca_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (mix_exp_q.size() == 0) begin
        flag_error($sformatf("unexpected result mixed_sample=%0d idle=%0b",
                             result_o.mixed_sample, result_o.idle));
      end else begin
        exp_r = mix_exp_q.pop_front();
        if (result_o.mixed_sample !== exp_r.mixed_sample)
          flag_error($sformatf("mixed_sample exp %0d got %0d",
                               exp_r.mixed_sample, result_o.mixed_sample));
        if (result_o.idle !== exp_r.idle)
          flag_error($sformatf("idle exp %0b got %0b", exp_r.idle, result_o.idle));
      end
    end
  end

  initial begin
    err_cnt   = 0;
    cycle_cnt = 0;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    item_i    = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    for (int c = 0; c < HwChannels; c++) vol_q[c] = VolUnity;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_unity_mix();
    test_volume_limits();
    test_random_mix();

    drain();
    repeat (8) @(posedge clk_i);
    if (mix_exp_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", mix_exp_q.size()));
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
